// ----- hw/rtl/sqmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmf_pkg
// Shared types and constants of the square window morphology filter.
// ----------------------------------------------------------------------------
package sqmf_pkg;

    // Pixel range and frame limits fixed by the stream format
    localparam logic [7:0] PIX_MAX     = 8'd255;
    localparam int         FRAME_H_MAX = 4095;

    // Configuration register reset values
    localparam logic        RST_OP_SELECT    = 1'b0;
    localparam logic [2:0]  RST_RADIUS       = 3'd1;
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;

    // Configuration register map
    typedef enum logic [1:0] {
        CFG_OP_SELECT    = 2'd0,
        CFG_RADIUS       = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } t_cfg_index;

    // Operation select codes
    localparam logic OP_DILATE = 1'b0;
    localparam logic OP_ERODE  = 1'b1;

    // Input item: pixel or flush tick
    typedef struct packed {
        logic       mode;
        logic [7:0] pixel;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0]  out_pixel;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic        last_of_frame;
    } t_out_item;

endpackage
`default_nettype wire

// ----- hw/rtl/sqmf_line_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmf_line_mem
// Column history memory, one registered read port and one write port, with
// forwarding of a write that lands on the edge of a read to the same entry.
// ----------------------------------------------------------------------------
module sqmf_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [DW-1:0] r_fwd_data;
    logic          r_fwd_hit;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Same-edge write/read collision tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule
`default_nettype wire

// ----- hw/rtl/square_window_morphology_filter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_window_morphology_filter_top
// Raster-order grayscale dilation / all-255 erosion over a square window.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in      | sink      | i_in_valid/o_in_ready  | i_in_data  (t_in_item)
//   out     | source    | o_out_valid/i_out_ready| o_out_data (t_out_item)
//   cfg     | sink      | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; a result
// leaves via column read, column reduce, row reduce and the output register.
// The rate is set by the single column-history memory: one read-modify-write
// per tick, with same-column back-to-back ticks served by forwarding.
// After reset or a register write the input is held off while the frame
// size products settle. Output stalls back up stage by stage.
// ----------------------------------------------------------------------------
module square_window_morphology_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire sqmf_pkg::t_in_item    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output sqmf_pkg::t_out_item        o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire sqmf_pkg::t_cfg_index  i_cfg_index,
    input  wire logic [11:0]           i_cfg_data
);

    import sqmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int XW    = CW + 2;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int ROWCW = $clog2(FRAME_H_MAX + MAX_RADIUS + 2);
    localparam int TW    = $clog2(MAX_WIDTH * (FRAME_H_MAX + MAX_RADIUS) + MAX_RADIUS + 1);
    localparam int NH    = 2 * MAX_RADIUS;
    localparam int NT    = 2 * MAX_RADIUS + 1;
    localparam int MW    = 8 * NH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_op;
    logic [2:0]  r_radius;
    logic [10:0] r_fw;
    logic [11:0] r_fh;
    logic [1:0]  r_hold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= RST_OP_SELECT;
            r_radius <= RST_RADIUS;
            r_fw     <= RST_FRAME_WIDTH;
            r_fh     <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OP_SELECT:    r_op     <= i_cfg_data[0];
                CFG_RADIUS:       r_radius <= i_cfg_data[2:0];
                CFG_FRAME_WIDTH:  r_fw     <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_fh     <= i_cfg_data;
                default:          r_op     <= r_op;
            endcase
        end
    end

    // Settle time for the derived frame figures
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_hold <= 2'd3;
        end else if (r_hold != 2'd0) begin
            r_hold <= r_hold - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Effective sizes and frame figures
    // ------------------------------------------------------------------
    logic [WW-1:0] n_w, r_w;
    logic [11:0]   n_h, r_h;
    logic [RW-1:0] n_r, r_r;
    logic [TW-1:0] r_total, r_delay, r_end;

    always_comb begin
        if (r_fw == 11'd0) begin
            n_w = WW'(1);
        end else if (14'(r_fw) > 14'(MAX_WIDTH)) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(r_fw);
        end
        n_h = (r_fh == 12'd0) ? 12'd1 : r_fh;
        if (5'(r_radius) > 5'(MAX_RADIUS)) begin
            n_r = RW'(MAX_RADIUS);
        end else begin
            n_r = RW'(r_radius);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_h     <= n_h;
        r_r     <= n_r;
        r_total <= TW'(r_w) * TW'(r_h);
        r_delay <= TW'(r_r) * TW'(r_w) + TW'(r_r);
        r_end   <= r_total + r_delay;
    end

    // ------------------------------------------------------------------
    // Stage handshakes
    // ------------------------------------------------------------------
    logic r_b_valid, r_c_valid, r_o_valid;
    logic en_out, en_c, en_b, in_xfer;

    assign en_out     = !r_o_valid || i_out_ready;
    assign en_c       = en_out || !r_c_valid;
    assign en_b       = en_c || !r_b_valid;
    assign o_in_ready = en_b && (r_hold == 2'd0);
    assign in_xfer    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Tick position counters
    // ------------------------------------------------------------------
    logic [TW-1:0]    r_t;
    logic [ROWCW-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [11:0]      r_orow;
    logic [CW-1:0]    r_ocol;
    logic             in_frame, counts, has_res, frame_end;

    assign in_frame  = r_t < r_total;
    assign counts    = !(in_frame && i_in_data.mode);
    assign has_res   = r_t >= r_delay;
    assign frame_end = (r_t + TW'(1)) >= r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_t    <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_orow <= '0;
            r_ocol <= '0;
        end else if (in_xfer && counts) begin
            if (frame_end) begin
                r_t    <= '0;
                r_row  <= '0;
                r_col  <= '0;
                r_orow <= '0;
                r_ocol <= '0;
            end else begin
                r_t <= r_t + TW'(1);
                if ((WW'(r_col) + WW'(1)) >= r_w) begin
                    r_col <= '0;
                    r_row <= r_row + ROWCW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
                if (has_res) begin
                    if ((WW'(r_ocol) + WW'(1)) >= r_w) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + 12'd1;
                    end else begin
                        r_ocol <= r_ocol + CW'(1);
                    end
                end
            end
        end
    end

    // Rows of the column history that fall inside the frame
    logic [NH-1:0] n_hmask;

    always_comb begin
        for (int i = 0; i < NH; i++) begin
            n_hmask[i] = (RW'(i / 2) < r_r)
                      && ((ROWCW + 1)'(r_row) > (ROWCW + 1)'(i))
                      && ((ROWCW + 1)'(r_row) <= ((ROWCW + 1)'(r_h) + (ROWCW + 1)'(i)));
        end
    end

    // ------------------------------------------------------------------
    // Stage B: column history read-modify-write and column reduce
    // ------------------------------------------------------------------
    logic [7:0]    r_b_pix;
    logic          r_b_cur, r_b_res, r_b_last;
    logic [NH-1:0] r_b_hmask;
    logic [11:0]   r_b_orow;
    logic [CW-1:0] r_b_ocol, r_b_addr;
    logic [MW-1:0] hist;
    logic          mem_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= in_xfer && counts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_pix   <= i_in_data.pixel;
            r_b_cur   <= in_frame;
            r_b_res   <= has_res;
            r_b_last  <= frame_end;
            r_b_hmask <= n_hmask;
            r_b_orow  <= r_orow;
            r_b_ocol  <= r_ocol;
            r_b_addr  <= r_col;
        end
    end

    assign mem_wr = r_b_valid && en_c;

    sqmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (MW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en_b),
        .i_rd_addr (r_col),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_b_addr),
        .i_wr_data ({hist[MW-9:0], r_b_pix}),
        .o_rd_data (hist)
    );

    // Column value for center row R-r
    logic [7:0]    colv;
    logic [7:0]    slot;
    logic [XW-1:0] base;
    logic [NT-1:0] n_tmask;

    always_comb begin
        colv = (r_op == OP_ERODE) ? PIX_MAX : 8'd0;
        if (r_b_cur) begin
            colv = r_b_pix;
        end
        for (int i = 0; i < NH; i++) begin
            slot = hist[8*i +: 8];
            if (r_b_hmask[i]) begin
                if (r_op == OP_ERODE) begin
                    colv = (slot < colv) ? slot : colv;
                end else begin
                    colv = (slot > colv) ? slot : colv;
                end
            end
        end
    end

    // Taps that belong to the output row, limited to the frame columns
    assign base = XW'(r_b_ocol) + XW'(r_r);

    always_comb begin
        for (int d = 0; d < NT; d++) begin
            n_tmask[d] = (XW'(d) <= (XW'(r_r) << 1))
                      && (base >= XW'(d))
                      && ((base - XW'(d)) <= (XW'(r_w) - XW'(1)));
        end
    end

    // ------------------------------------------------------------------
    // Stage C: row window taps and row reduce
    // ------------------------------------------------------------------
    logic [7:0]    r_taps [NT];
    logic [NT-1:0] r_c_tmask;
    logic          r_c_res, r_c_last;
    logic [11:0]   r_c_row;
    logic [CW-1:0] r_c_col;
    logic [7:0]    winv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_valid) begin
            r_taps[0] <= colv;
            for (int d = 1; d < NT; d++) begin
                r_taps[d] <= r_taps[d-1];
            end
            r_c_tmask <= n_tmask;
            r_c_res   <= r_b_res;
            r_c_last  <= r_b_last;
            r_c_row   <= r_b_orow;
            r_c_col   <= r_b_ocol;
        end
    end

    always_comb begin
        winv = (r_op == OP_ERODE) ? PIX_MAX : 8'd0;
        for (int d = 0; d < NT; d++) begin
            if (r_c_tmask[d]) begin
                if (r_op == OP_ERODE) begin
                    winv = (r_taps[d] < winv) ? r_taps[d] : winv;
                end else begin
                    winv = (r_taps[d] > winv) ? r_taps[d] : winv;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_out_item r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= r_c_valid && r_c_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            if (r_op == OP_ERODE) begin
                r_o_data.out_pixel <= (winv == PIX_MAX) ? PIX_MAX : 8'd0;
            end else begin
                r_o_data.out_pixel <= winv;
            end
            r_o_data.out_row       <= r_c_row;
            r_o_data.out_col       <= 10'(r_c_col);
            r_o_data.last_of_frame <= r_c_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold != 2'd0) |-> !o_in_ready)
        else $error("input taken before frame figures settled");

    a_cfg_clears_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_t == '0) && (r_col == '0) && (r_ocol == '0))
        else $error("register write did not restart the frame position");

    a_stalled_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !en_c) |=> (r_b_valid && $stable(r_b_addr) && $stable(r_b_pix)))
        else $error("column stage item lost under stall");

    a_last_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_res && r_c_last) |-> (r_c_row == (r_h - 12'd1)))
        else $error("end of frame flagged off the last row");

endmodule
`default_nettype wire
